[sv/assert_macros.svh]
// Assertion macros shared by the interpolator RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property that is not checked while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked property that is checked on every edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

[sv/tgi_pkg.sv]
// Shared types and constants for the trilinear grid interpolator.
// Depends on nothing; used by every module of the block.
package tgi_pkg;

    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 32;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_SMOOTH_MODE = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_THREE_DIMS  = 2'd1;

    typedef struct packed {
        logic smooth_mode;
        logic three_dims;
    } cfg_t;

    typedef struct packed {
        logic load_a;
        logic load_b;
        logic valid_a;
    } stage_ctrl_t;

endpackage

[sv/tgi_weight.sv]
// Two-stage weight unit: saturates the three fractions and applies smoothstep in smooth mode.
// Depends on tgi_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tgi_weight #(
    parameter int FRAC_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tgi_pkg::stage_ctrl_t ctrl,
    input  tgi_pkg::cfg_t        cfg,
    input  logic [FRAC_BITS:0]   frac_x,
    input  logic [FRAC_BITS:0]   frac_y,
    input  logic [FRAC_BITS:0]   frac_z,
    output logic [FRAC_BITS:0]   w_x,
    output logic [FRAC_BITS:0]   w_y,
    output logic [FRAC_BITS:0]   w_z
);

    localparam int SQW = 2 * FRAC_BITS + 2;
    localparam int SMW = 2 * FRAC_BITS + 3;
    localparam logic [FRAC_BITS:0]   ONE       = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [FRAC_BITS+1:0] THREE_ONE = {2'b11, {FRAC_BITS{1'b0}}};

    logic [FRAC_BITS:0]   frac_in [3];
    logic [FRAC_BITS:0]   t_next [3];
    logic [FRAC_BITS:0]   t_reg [3];
    logic [SQW-1:0]       sq_full [3];
    logic [FRAC_BITS:0]   sq_next [3];
    logic [FRAC_BITS:0]   sq_reg [3];
    logic [FRAC_BITS+1:0] slope [3];
    logic [SMW-1:0]       sm_full [3];
    logic [FRAC_BITS:0]   w_next [3];
    logic [FRAC_BITS:0]   w_reg [3];

    always_comb
    begin
        frac_in[0] = frac_x;
        frac_in[1] = frac_y;
        frac_in[2] = frac_z;
        for (int i = 0; i < 3; i++)
        begin
            t_next[i]  = (frac_in[i] > ONE) ? ONE : frac_in[i];
            sq_full[i] = SQW'(t_next[i]) * SQW'(t_next[i]);
            sq_next[i] = sq_full[i][FRAC_BITS +: FRAC_BITS+1];
            slope[i]   = THREE_ONE - {t_reg[i], 1'b0};
            sm_full[i] = SMW'(sq_reg[i]) * SMW'(slope[i]);
            w_next[i]  = cfg.smooth_mode ? sm_full[i][FRAC_BITS +: FRAC_BITS+1] : t_reg[i];
        end
        if (!cfg.three_dims)
        begin
            w_next[2] = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_a)
        begin
            t_reg  <= t_next;
            sq_reg <= sq_next;
        end
        if (ctrl.load_b)
        begin
            w_reg <= w_next;
        end
    end

    assign w_x = w_reg[0];
    assign w_y = w_reg[1];
    assign w_z = w_reg[2];

    `ASSERT_CLK(a_bilinear_z_weight_zero, clk, rst_n, ctrl.load_b && !cfg.three_dims |=> w_z == '0, "z weight is not zero in bilinear mode")
    `ASSERT_CLK(a_weights_within_one, clk, rst_n, ctrl.load_b && ctrl.valid_a |=> (w_x <= ONE && w_y <= ONE && w_z <= ONE), "weight above one")

endmodule

[sv/tgi_lerp.sv]
// Two-stage exact linear blend of two signed values by one Q1.F weight.
// Depends on tgi_pkg; the value is split in halves to keep multipliers narrow.
module tgi_lerp #(
    parameter int VALUE_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                  clk,
    input  tgi_pkg::stage_ctrl_t                  ctrl,
    input  logic signed [VALUE_BITS-1:0]          v0,
    input  logic signed [VALUE_BITS-1:0]          v1,
    input  logic [FRAC_BITS:0]                    f,
    output logic signed [VALUE_BITS+FRAC_BITS-1:0] result
);

    localparam int LO  = VALUE_BITS / 2;
    localparam int HI  = VALUE_BITS - LO;
    localparam int LPW = LO + FRAC_BITS + 1;
    localparam int HPW = HI + FRAC_BITS + 2;
    localparam int SW  = VALUE_BITS + FRAC_BITS + 2;
    localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

    logic [FRAC_BITS:0]                     w0;
    logic [LPW-1:0]                         lo0_next, lo1_next, lo0_reg, lo1_reg;
    logic signed [HPW-1:0]                  hi0_next, hi1_next, hi0_reg, hi1_reg;
    logic [SW-1:0]                          sum;
    logic signed [VALUE_BITS+FRAC_BITS-1:0] result_reg;

    assign w0 = ONE - f;

    always_comb
    begin
        lo0_next = LPW'(v0[LO-1:0]) * LPW'(w0);
        lo1_next = LPW'(v1[LO-1:0]) * LPW'(f);
        hi0_next = HPW'($signed(v0[VALUE_BITS-1:LO])) * $signed(HPW'(w0));
        hi1_next = HPW'($signed(v1[VALUE_BITS-1:LO])) * $signed(HPW'(f));
        sum = (SW'(hi0_reg) << LO) + (SW'(hi1_reg) << LO) + SW'(lo0_reg) + SW'(lo1_reg);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_a)
        begin
            lo0_reg <= lo0_next;
            lo1_reg <= lo1_next;
            hi0_reg <= hi0_next;
            hi1_reg <= hi1_next;
        end
        if (ctrl.load_b)
        begin
            result_reg <= sum[VALUE_BITS+FRAC_BITS-1:0];
        end
    end

    assign result = result_reg;

endmodule

[sv/trilinear_grid_interpolator_unit.sv]
// Top level of the trilinear grid interpolator: handshake, pipeline and config.
// Depends on tgi_pkg, tgi_weight, tgi_lerp and assert_macros.svh.
//
// Usage: a request on the input channel carries the eight corner samples of a
// grid cell and three Q1.FRAC_BITS positions; the output channel returns one
// rounded sample per request, in order. Both channels use valid and ready.
// The configuration channel is always ready; index 0 selects smoothstep
// weights, index 1 selects three dimensions (0 blends the z=0 corners only).
// Write it only while no request is in flight.
// The stages are two for the weights, two each for the x, y and z blends,
// then rounding. Throughput is one request per cycle while the receiver takes
// results; each blend holds one multiplier rank.
// Every stage carries its own valid bit and loads whenever it is empty or
// its successor moves, so bubbles close up and requests are accepted while a
// finished result waits. When the receiver stalls, the pipeline fills and
// in_ready drops; nothing is dropped or repeated.
// Reset empties the pipeline, sets linear weighting and three dimensions.
`include "assert_macros.svh"

module trilinear_grid_interpolator_unit #(
    parameter int SAMPLE_BITS = 16,
    parameter int FRAC_BITS   = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [SAMPLE_BITS-1:0]      corner_000,
    input  logic signed [SAMPLE_BITS-1:0]      corner_100,
    input  logic signed [SAMPLE_BITS-1:0]      corner_010,
    input  logic signed [SAMPLE_BITS-1:0]      corner_110,
    input  logic signed [SAMPLE_BITS-1:0]      corner_001,
    input  logic signed [SAMPLE_BITS-1:0]      corner_101,
    input  logic signed [SAMPLE_BITS-1:0]      corner_011,
    input  logic signed [SAMPLE_BITS-1:0]      corner_111,
    input  logic [FRAC_BITS:0]                 frac_x,
    input  logic [FRAC_BITS:0]                 frac_y,
    input  logic [FRAC_BITS:0]                 frac_z,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [SAMPLE_BITS-1:0]      blended_value,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [tgi_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [tgi_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

    localparam int NUM_STAGES = 9;
    localparam int AW = SAMPLE_BITS + FRAC_BITS;
    localparam int BW = SAMPLE_BITS + 2 * FRAC_BITS;
    localparam int CW = SAMPLE_BITS + 3 * FRAC_BITS;
    localparam logic [CW-1:0] HALF = CW'(1) << (3 * FRAC_BITS - 1);

    logic [NUM_STAGES:1]          vld_reg, vld_next;
    logic [NUM_STAGES:1]          adv;
    logic                         smooth_mode_reg;
    logic                         three_dims_reg;
    tgi_pkg::cfg_t                cfg;
    logic signed [SAMPLE_BITS-1:0] corner_in [8];
    logic signed [SAMPLE_BITS-1:0] c1_reg [8];
    logic signed [SAMPLE_BITS-1:0] c2_reg [8];
    logic [FRAC_BITS:0]           w_x, w_y, w_z;
    logic [FRAC_BITS:0]           fy3_reg, fy4_reg;
    logic [FRAC_BITS:0]           fz3_reg, fz4_reg, fz5_reg, fz6_reg;
    logic signed [AW-1:0]         a_val [4];
    logic signed [BW-1:0]         b_val [2];
    logic signed [CW-1:0]         c_val;
    logic [CW-1:0]                rounded;
    logic signed [SAMPLE_BITS-1:0] blended_reg;
    tgi_pkg::stage_ctrl_t         weight_ctrl, x_ctrl, y_ctrl, z_ctrl;

    // Stage handshake: a stage loads when empty or when its successor moves.
    always_comb
    begin
        adv[NUM_STAGES] = !vld_reg[NUM_STAGES] || out_ready;
        for (int k = NUM_STAGES - 1; k >= 1; k--)
        begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
        vld_next[1] = adv[1] ? in_valid : vld_reg[1];
        for (int k = 2; k <= NUM_STAGES; k++)
        begin
            vld_next[k] = adv[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign in_ready  = adv[1];
    assign out_valid = vld_reg[NUM_STAGES];
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smooth_mode_reg <= 1'b0;
            three_dims_reg  <= 1'b1;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                tgi_pkg::CFG_SMOOTH_MODE: smooth_mode_reg <= cfg_data[0];
                tgi_pkg::CFG_THREE_DIMS:  three_dims_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign cfg.smooth_mode = smooth_mode_reg;
    assign cfg.three_dims  = three_dims_reg;

    assign corner_in[0] = corner_000;
    assign corner_in[1] = corner_100;
    assign corner_in[2] = corner_010;
    assign corner_in[3] = corner_110;
    assign corner_in[4] = corner_001;
    assign corner_in[5] = corner_101;
    assign corner_in[6] = corner_011;
    assign corner_in[7] = corner_111;

    assign weight_ctrl = '{load_a: adv[1], load_b: adv[2], valid_a: vld_reg[1]};
    assign x_ctrl      = '{load_a: adv[3], load_b: adv[4], valid_a: vld_reg[3]};
    assign y_ctrl      = '{load_a: adv[5], load_b: adv[6], valid_a: vld_reg[5]};
    assign z_ctrl      = '{load_a: adv[7], load_b: adv[8], valid_a: vld_reg[7]};

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            c1_reg <= corner_in;
        end
        if (adv[2])
        begin
            c2_reg <= c1_reg;
        end
        if (adv[3])
        begin
            fy3_reg <= w_y;
            fz3_reg <= w_z;
        end
        if (adv[4])
        begin
            fy4_reg <= fy3_reg;
            fz4_reg <= fz3_reg;
        end
        if (adv[5])
        begin
            fz5_reg <= fz4_reg;
        end
        if (adv[6])
        begin
            fz6_reg <= fz5_reg;
        end
        if (adv[9])
        begin
            blended_reg <= rounded[CW-1 -: SAMPLE_BITS];
        end
    end

    tgi_weight #(
        .FRAC_BITS (FRAC_BITS)
    ) u_weight (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (weight_ctrl),
        .cfg    (cfg),
        .frac_x (frac_x),
        .frac_y (frac_y),
        .frac_z (frac_z),
        .w_x    (w_x),
        .w_y    (w_y),
        .w_z    (w_z)
    );

    for (genvar j = 0; j < 4; j++)
    begin : g_x_blend
        tgi_lerp #(
            .VALUE_BITS (SAMPLE_BITS),
            .FRAC_BITS  (FRAC_BITS)
        ) u_lerp (
            .clk    (clk),
            .ctrl   (x_ctrl),
            .v0     (c2_reg[2*j]),
            .v1     (c2_reg[2*j+1]),
            .f      (w_x),
            .result (a_val[j])
        );
    end

    for (genvar m = 0; m < 2; m++)
    begin : g_y_blend
        tgi_lerp #(
            .VALUE_BITS (AW),
            .FRAC_BITS  (FRAC_BITS)
        ) u_lerp (
            .clk    (clk),
            .ctrl   (y_ctrl),
            .v0     (a_val[2*m]),
            .v1     (a_val[2*m+1]),
            .f      (fy4_reg),
            .result (b_val[m])
        );
    end

    tgi_lerp #(
        .VALUE_BITS (BW),
        .FRAC_BITS  (FRAC_BITS)
    ) u_z_blend (
        .clk    (clk),
        .ctrl   (z_ctrl),
        .v0     (b_val[0]),
        .v1     (b_val[1]),
        .f      (fz6_reg),
        .result (c_val)
    );

    // Round half up, then drop the three fraction fields.
    assign rounded       = c_val + HALF;
    assign blended_value = blended_reg;

    `ASSERT_CLK(a_empty_output_takes_request, clk, rst_n, !vld_reg[NUM_STAGES] |-> in_ready, "input stalled with an empty output stage")
    `ASSERT_CLK(a_request_enters_pipeline, clk, rst_n, in_valid && in_ready |=> vld_reg[1], "accepted request missing from first stage")
    `ASSERT_CLK(a_result_reaches_output, clk, rst_n, vld_reg[NUM_STAGES-1] && adv[NUM_STAGES] |=> out_valid, "result lost before the output stage")

endmodule
